// ===== design/urc_pkg.sv =====
// Shared constants, register codes and types for the ultrasonic range controller.
`timescale 1ns / 1ps
`default_nettype none

package urc_pkg;

    localparam int ECHO_COUNT_WIDTH = 16;

    localparam int PERIOD_W   = 20;
    localparam int TRIG_W     = 8;
    localparam int DIST_W     = 14;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    // Echo count times 17, then floor division by 100 through a reciprocal.
    localparam int PROD_W      = ECHO_COUNT_WIDTH + 5;
    localparam int RECIP_SHIFT = PROD_W + 7;
    localparam int RECIP_W     = RECIP_SHIFT - 6;
    localparam int QUOT_W      = PROD_W - 6;
    localparam int CMP_W       = (QUOT_W > DIST_W) ? QUOT_W : DIST_W;
    localparam logic [RECIP_W-1:0] RECIP_MULT =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);

    localparam logic                  RST_ENABLE         = 1'b1;
    localparam logic [PERIOD_W-1:0]   RST_POLL_PERIOD    = PERIOD_W'(20000);
    localparam logic [TRIG_W-1:0]     RST_TRIGGER_WIDTH  = TRIG_W'(12);
    localparam logic [DIST_W-1:0]     RST_MAX_DISTANCE   = DIST_W'(2000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE,
        REG_POLL_PERIOD,
        REG_TRIGGER_WIDTH,
        REG_MAX_DISTANCE
    } cfg_reg_t;

    typedef struct packed {
        logic                enable;
        logic [PERIOD_W-1:0] poll_period_us;
        logic [TRIG_W-1:0]   trigger_width_us;
        logic [DIST_W-1:0]   max_distance_mm;
    } cfg_t;

    typedef struct packed {
        logic              trigger_level;
        logic              distance_valid;
        logic [PROD_W-1:0] echo_product;
    } tick_res_t;

endpackage

`default_nettype wire

// ===== design/urc_tick_ctrl.sv =====
// Trigger period counter and echo pulse timer, advanced once per accepted tick.
`timescale 1ns / 1ps
`default_nettype none

module urc_tick_ctrl
    import urc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      step,
    input  wire logic      echo_level,
    input  wire cfg_t      cfg,
    output tick_res_t      res
);

    logic [PERIOD_W-1:0]         period_count_reg, period_count_next;
    logic [ECHO_COUNT_WIDTH-1:0] echo_count_reg, echo_count_next;
    logic                        echo_prev_reg, echo_prev_next;
    logic                        measuring_reg, measuring_next;
    logic [PERIOD_W:0]           period_inc;

    always_comb begin
        period_inc        = {1'b0, period_count_reg} + (PERIOD_W + 1)'(1);
        period_count_next = '0;
        res.trigger_level = 1'b0;
        if (cfg.enable) begin
            res.trigger_level = (period_count_reg < PERIOD_W'(cfg.trigger_width_us));
            if (period_inc >= {1'b0, cfg.poll_period_us}) begin
                period_count_next = '0;
            end else begin
                period_count_next = period_inc[PERIOD_W-1:0];
            end
        end

        echo_count_next    = echo_count_reg;
        measuring_next     = measuring_reg;
        res.distance_valid = 1'b0;
        if (echo_level) begin
            if (!echo_prev_reg) begin
                measuring_next  = 1'b1;
                echo_count_next = ECHO_COUNT_WIDTH'(1);
            end else if (measuring_reg && (echo_count_reg != '1)) begin
                echo_count_next = echo_count_reg + ECHO_COUNT_WIDTH'(1);
            end
        end else if (echo_prev_reg && measuring_reg) begin
            res.distance_valid = 1'b1;
            measuring_next     = 1'b0;
        end
        echo_prev_next = echo_level;

        res.echo_product = {1'b0, echo_count_reg, 4'b0000} + PROD_W'(echo_count_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_count_reg <= '0;
            echo_count_reg   <= '0;
            echo_prev_reg    <= 1'b0;
            measuring_reg    <= 1'b0;
        end else if (step) begin
            period_count_reg <= period_count_next;
            echo_count_reg   <= echo_count_next;
            echo_prev_reg    <= echo_prev_next;
            measuring_reg    <= measuring_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/ultrasonic_range_controller_unit.sv =====
// Top level of the ultrasonic range controller: configuration, pipeline and stream ports.
// A result passes through the stage-1 registers and the output register to the master side.
// Throughput: one transaction per cycle unless m_tready stalls the output; the tick
// counters update at the accepting edge, and a two-stage pipeline (times 17, then a
// reciprocal multiply for the division by 100) carries the result to the output register.
// Reset: aresetn clears all counters and pipeline valid bits and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_range_controller_unit
    import urc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [0] echo_level, [7:1] zero

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata,   // [0] trigger_level, [14:1] distance_mm
    output logic                       m_tuser    // [0] distance_valid
);

    cfg_t      cfg_reg;
    tick_res_t tick_res;

    logic              st1_valid_reg;
    logic              st1_trig_reg;
    logic              st1_dvalid_reg;
    logic [PROD_W-1:0] st1_prod_reg;

    logic              out_valid_reg;
    logic              out_trig_reg;
    logic              out_dvalid_reg;
    logic [DIST_W-1:0] out_dist_reg, out_dist_next;

    logic                          st2_ready;
    logic                          in_fire;
    logic [PROD_W+RECIP_W-1:0]     mult_full;
    logic [CMP_W-1:0]              quot_ext;

    assign st2_ready = !out_valid_reg || m_tready;
    assign s_tready  = !st1_valid_reg || st2_ready;
    assign in_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable           <= RST_ENABLE;
            cfg_reg.poll_period_us   <= RST_POLL_PERIOD;
            cfg_reg.trigger_width_us <= RST_TRIGGER_WIDTH;
            cfg_reg.max_distance_mm  <= RST_MAX_DISTANCE;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_ENABLE:        cfg_reg.enable           <= cfg_wdata[0];
                REG_POLL_PERIOD:   cfg_reg.poll_period_us   <= cfg_wdata[PERIOD_W-1:0];
                REG_TRIGGER_WIDTH: cfg_reg.trigger_width_us <= cfg_wdata[TRIG_W-1:0];
                REG_MAX_DISTANCE:  cfg_reg.max_distance_mm  <= cfg_wdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    urc_tick_ctrl u_tick_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (in_fire),
        .echo_level (s_tdata[0]),
        .cfg        (cfg_reg),
        .res        (tick_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            st1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            st1_trig_reg   <= tick_res.trigger_level;
            st1_dvalid_reg <= tick_res.distance_valid;
            st1_prod_reg   <= tick_res.echo_product;
        end
    end

    always_comb begin
        mult_full = {{RECIP_W{1'b0}}, st1_prod_reg} * {{PROD_W{1'b0}}, RECIP_MULT};
        quot_ext  = CMP_W'(mult_full[RECIP_SHIFT +: QUOT_W]);
        if (st1_dvalid_reg && (quot_ext <= CMP_W'(cfg_reg.max_distance_mm))) begin
            out_dist_next = quot_ext[DIST_W-1:0];
        end else begin
            out_dist_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (st2_ready) begin
            out_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st2_ready && st1_valid_reg) begin
            out_trig_reg   <= st1_trig_reg;
            out_dvalid_reg <= st1_dvalid_reg;
            out_dist_reg   <= out_dist_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_dist_reg, out_trig_reg};
    assign m_tuser  = out_dvalid_reg;

endmodule

`default_nettype wire
